[rtl/lattice_median_outlier_filter_defines.svh]
// Assertion macros shared by the lattice median outlier filter RTL.
`ifndef LATTICE_MEDIAN_OUTLIER_FILTER_DEFINES_SVH
`define LATTICE_MEDIAN_OUTLIER_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMOF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lmof_pkg.sv]
// Shared constants, types and helpers of the lattice median outlier filter.
package lmof_pkg;

    localparam int IMG_W      = 64;
    localparam int IMG_H      = 64;
    localparam int MAX_RADIUS = 3;

    localparam int PIX_W      = 16;
    localparam int POS_W      = 6;
    localparam int STEP_W     = 7;
    localparam int RAD_W      = 2;
    localparam int THR_W      = 16;
    localparam int PASS_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NPIX     = IMG_W * IMG_H;
    localparam int ADDR_W   = $clog2(NPIX);
    localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
    localparam int NWIN     = WIN_SIDE * WIN_SIDE;
    localparam int WIN_AW   = $clog2(NWIN);
    localparam int CNT_W    = $clog2(NWIN + 1);
    localparam int KW       = $clog2(WIN_SIDE);
    localparam int MAX_DIM  = (IMG_W > IMG_H) ? IMG_W : IMG_H;
    // signed coordinate wide enough for a point plus or minus a full window reach
    localparam int CW       = $clog2(MAX_DIM + MAX_RADIUS * 128) + 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASSES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y  = 3'd6;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_LSTART,
        S_PT,
        S_GATHER,
        S_CENTER,
        S_CWAIT,
        S_CAND,
        S_CANDW,
        S_COUNT,
        S_EVAL,
        S_EVAL2,
        S_DEC,
        S_PEND,
        S_DONE
    } state_t;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic clr;
        logic en;
    } rank_ctl_t;

    typedef struct packed {
        logic                    valid;
        logic signed [PIX_W-1:0] value;
    } dec_t;

    function automatic logic [ADDR_W-1:0] img_addr(input coord_t x, input coord_t y);
        logic [ADDR_W-1:0] xa;
        logic [ADDR_W-1:0] ya;
        xa = ADDR_W'($unsigned(x));
        ya = ADDR_W'($unsigned(y));
        return ADDR_W'(xa * ADDR_W'(IMG_H) + ya);
    endfunction

endpackage

[rtl/lmof_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lmof_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/lmof_rank.sv]
// Shared compare-and-count unit: ranks a candidate against streamed window values.
module lmof_rank
    import lmof_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rank_ctl_t               ctl,
    input  logic signed [PIX_W-1:0] sample,
    input  logic signed [PIX_W-1:0] cand,
    output logic [CNT_W-1:0]        lt_cnt,
    output logic [CNT_W-1:0]        le_cnt
);

    logic [CNT_W-1:0] lt_reg, lt_next;
    logic [CNT_W-1:0] le_reg, le_next;

    // count samples below and not above the candidate
    always_comb
    begin
        lt_next = lt_reg;
        le_next = le_reg;
        if (ctl.clr)
        begin
            lt_next = '0;
            le_next = '0;
        end
        else if (ctl.en)
        begin
            if (sample < cand)
            begin
                lt_next = lt_reg + CNT_W'(1);
            end
            if (sample <= cand)
            begin
                le_next = le_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= '0;
            le_reg <= '0;
        end
        else
        begin
            lt_reg <= lt_next;
            le_reg <= le_next;
        end
    end

    assign lt_cnt = lt_reg;
    assign le_cnt = le_reg;

endmodule

[rtl/lmof_outlier.sv]
// Two-stage outlier test: replace p by m when 1024|p-m| > t(3|m|+|p|).
module lmof_outlier
    import lmof_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [PIX_W-1:0] p,
    input  logic signed [PIX_W-1:0] m,
    input  logic [THR_W-1:0]        thr,
    output dec_t                    dec
);

    localparam int DIFF_W = PIX_W + 1;
    localparam int LHS_W  = PIX_W + 10;
    localparam int SUM_W  = PIX_W + 2;
    localparam int RHS_W  = THR_W + SUM_W;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        abs_d;
    logic [DIFF_W-1:0]        abs_p;
    logic [DIFF_W-1:0]        abs_m;

    logic                    v1_reg, v2_reg;
    logic [LHS_W-1:0]        lhs1_reg, lhs2_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic signed [PIX_W-1:0] p1_reg, p2_reg, m1_reg, m2_reg;
    logic [RHS_W-1:0]        rhs_reg;

    // absolute values at one bit of headroom
    always_comb
    begin
        diff  = DIFF_W'(p) - DIFF_W'(m);
        abs_d = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        abs_p = p[PIX_W-1] ? DIFF_W'(-DIFF_W'(p)) : DIFF_W'(p);
        abs_m = m[PIX_W-1] ? DIFF_W'(-DIFF_W'(m)) : DIFF_W'(m);
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // stage one: scaled error and weighted magnitude; stage two: multiply
    always_ff @(posedge clk)
    begin
        lhs1_reg <= LHS_W'(abs_d) << 10;
        sum_reg  <= SUM_W'(abs_m) * SUM_W'(3) + SUM_W'(abs_p);
        p1_reg   <= p;
        m1_reg   <= m;
        lhs2_reg <= lhs1_reg;
        rhs_reg  <= RHS_W'(thr) * RHS_W'(sum_reg);
        p2_reg   <= p1_reg;
        m2_reg   <= m1_reg;
    end

    assign dec.valid = v2_reg;
    assign dec.value = (RHS_W'(lhs2_reg) > rhs_reg) ? m2_reg : p2_reg;

endmodule

[rtl/lattice_median_outlier_filter.sv]
// Top level: image banks, window store, run sequencer and host channels.
//
// Usage: items arrive on in_valid/in_ready with cmd, pos_x, pos_y, pixel_in;
// every item yields exactly one transfer on out_valid/out_ready (pixel_out).
// cmd 0 writes a pixel (result zero), cmd 2 reads one, cmd 1 runs pass_count
// filter passes (result zero when done), cmd 3 only answers zero.
// Registers are written on cfg_valid/cfg_ready (cfg_index, cfg_data); the
// port is always ready; the user must write it only while the block is idle,
// which the block does not enforce. A write or nop answers in the cycle
// after acceptance, a read after S_READ. Each pass of a run clears all NPIX
// (4096) words of the destination bank; per lattice point it then gathers
// the (2r+1)^2 window, runs a median search over the n gathered values
// through the one compare unit, and does point setup, center fetch, outlier
// test and write back. One item is in work at a time; in_ready is low while
// busy. After reset a clearing pass zeroes the active image bank, with
// in_ready low; configuration writes are taken meanwhile. A stalled
// receiver holds the result in the output register, and in_ready stays low
// until that result is taken or is taken in the same cycle.
`include "lattice_median_outlier_filter_defines.svh"

module lattice_median_outlier_filter
    import lmof_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic [POS_W-1:0]        pos_x,
    input  logic [POS_W-1:0]        pos_y,
    input  logic signed [PIX_W-1:0] pixel_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [PIX_W-1:0] pixel_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // configuration
    logic [RAD_W-1:0]  radius_reg;
    logic [THR_W-1:0]  thresh_reg;
    logic [PASS_W-1:0] passes_reg;
    logic [POS_W-1:0]  start_x_reg, start_y_reg;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;

    // sequencer state
    state_t            state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    coord_t            i_reg, i_next, j_reg, j_next;
    coord_t            tx_reg, tx_next, ty_reg, ty_next, ty0_reg, ty0_next;
    logic [KW-1:0]     kk_reg, kk_next, ll_reg, ll_next;
    logic [CNT_W-1:0]  n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic              gw_reg, gw_next;
    logic [WIN_AW-1:0] gidx_reg, gidx_next;
    logic              cmp_v_reg, cmp_v_next;
    logic              inside_reg, inside_next;
    logic signed [PIX_W-1:0] cand_reg, cand_next, p_reg, p_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [PIX_W-1:0] out_pixel_reg, out_pixel_next;

    // memory controls
    logic              img_we, img_wbank;
    logic [ADDR_W-1:0] img_waddr, img_raddr;
    logic [PIX_W-1:0]  img_wdata, img_rdata, rdata0, rdata1;
    logic              win_we;
    logic [WIN_AW-1:0] win_waddr, win_raddr;
    logic [PIX_W-1:0]  win_rdata;

    // other control
    rank_ctl_t               rank_ctl;
    logic [CNT_W-1:0]        lt_cnt, le_cnt;
    logic                    dec_start;
    dec_t                    dec;
    logic                    out_load;
    logic signed [PIX_W-1:0] out_value;
    logic                    accept;
    cmd_t                    cmd_c;

    // derived geometry
    logic [STEP_W-1:0] sxs, sys;
    coord_t            sx_c, sy_c, rsx, rsy;
    logic [RAD_W-1:0]  r_eff;
    logic [KW-1:0]     span;
    logic              tx_in, ty_in, pos_in, start_in, found;
    logic [CNT_W-1:0]  half;
    coord_t            j_step, i_step;
    logic [ADDR_W-1:0] pos_addr, ctr_addr, nb_addr;

    assign cmd_c  = cmd_t'(cmd);
    assign accept = in_valid && in_ready;

    // geometry helpers
    always_comb
    begin
        sxs      = (step_x_reg == '0) ? STEP_W'(1) : step_x_reg;
        sys      = (step_y_reg == '0) ? STEP_W'(1) : step_y_reg;
        sx_c     = $signed(CW'(sxs));
        sy_c     = $signed(CW'(sys));
        r_eff    = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
        span     = KW'(KW'(r_eff) << 1);
        rsx      = $signed(CW'(CW'(r_eff) * CW'(sxs)));
        rsy      = $signed(CW'(CW'(r_eff) * CW'(sys)));
        tx_in    = (tx_reg >= 0) && (tx_reg < $signed(CW'(IMG_W)));
        ty_in    = (ty_reg >= 0) && (ty_reg < $signed(CW'(IMG_H)));
        pos_in   = (32'(pos_x) < IMG_W) && (32'(pos_y) < IMG_H);
        start_in = (32'(start_x_reg) < IMG_W) && (32'(start_y_reg) < IMG_H);
        half     = n_reg >> 1;
        found    = (lt_cnt <= half) && (le_cnt > half);
        j_step   = j_reg + sy_c;
        i_step   = i_reg + sx_c;
        pos_addr = img_addr($signed(CW'(pos_x)), $signed(CW'(pos_y)));
        ctr_addr = img_addr(i_reg, j_reg);
        nb_addr  = img_addr(tx_reg, ty_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_reg == ADDR_W'(NPIX - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_c)
                        CMD_READ: state_next = S_READ;
                        CMD_RUN:  state_next = (passes_reg == '0) ? S_DONE : S_CLEAR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:   state_next = S_IDLE;
            S_CLEAR:
            begin
                if (clr_reg == ADDR_W'(NPIX - 1))
                begin
                    state_next = S_LSTART;
                end
            end
            S_LSTART: state_next = start_in ? S_PT : S_PEND;
            S_PT:     state_next = S_GATHER;
            S_GATHER:
            begin
                if ((kk_reg == span) && (ll_reg == span))
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER: state_next = S_CWAIT;
            S_CWAIT:  state_next = S_CAND;
            S_CAND:   state_next = S_CANDW;
            S_CANDW:  state_next = S_COUNT;
            S_COUNT:
            begin
                if (b_reg == n_reg - CNT_W'(1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:   state_next = S_EVAL2;
            S_EVAL2:  state_next = found ? S_DEC : S_CAND;
            S_DEC:
            begin
                if (dec.valid)
                begin
                    if ((j_step >= $signed(CW'(IMG_H))) && (i_step >= $signed(CW'(IMG_W))))
                    begin
                        state_next = S_PEND;
                    end
                    else
                    begin
                        state_next = S_PT;
                    end
                end
            end
            S_PEND:
            begin
                state_next = (pass_reg + PASS_W'(1) == passes_reg) ? S_DONE : S_CLEAR;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory, unit and handshake controls
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        img_we       = 1'b0;
        img_wbank    = ~bank_reg;
        img_waddr    = clr_reg;
        img_wdata    = '0;
        img_raddr    = pos_addr;
        win_we       = gw_reg;
        win_waddr    = gidx_reg;
        win_raddr    = a_reg[WIN_AW-1:0];
        rank_ctl.clr = 1'b0;
        rank_ctl.en  = cmp_v_reg;
        dec_start    = 1'b0;
        out_load     = 1'b0;
        out_value    = '0;
        case (state_reg)
            S_INIT:
            begin
                img_we    = 1'b1;
                img_wbank = bank_reg;
            end
            S_IDLE:
            begin
                if (accept && (cmd_c == CMD_WRITE))
                begin
                    img_we    = pos_in;
                    img_wbank = bank_reg;
                    img_waddr = pos_addr;
                    img_wdata = pixel_in;
                end
                out_load = accept && (cmd_c != CMD_READ) && (cmd_c != CMD_RUN);
            end
            S_READ:
            begin
                out_load  = 1'b1;
                out_value = inside_reg ? $signed(img_rdata) : '0;
            end
            S_CLEAR:  img_we = 1'b1;
            S_GATHER: img_raddr = nb_addr;
            S_CENTER: img_raddr = ctr_addr;
            S_CANDW:  rank_ctl.clr = 1'b1;
            S_COUNT:  win_raddr = b_reg[WIN_AW-1:0];
            S_EVAL2:  dec_start = found;
            S_DEC:
            begin
                img_we    = dec.valid;
                img_waddr = ctr_addr;
                img_wdata = dec.value;
            end
            S_DONE:   out_load = 1'b1;
            default:  img_we = 1'b0;
        endcase
    end

    // datapath next values
    always_comb
    begin
        bank_next   = bank_reg;
        clr_next    = clr_reg;
        pass_next   = pass_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        ty0_next    = ty0_reg;
        kk_next     = kk_reg;
        ll_next     = ll_reg;
        n_next      = n_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        gw_next     = 1'b0;
        gidx_next   = gidx_reg;
        cmp_v_next  = 1'b0;
        inside_next = inside_reg;
        cand_next   = cand_reg;
        p_next      = p_reg;
        case (state_reg)
            S_INIT:   clr_next = clr_reg + ADDR_W'(1);
            S_IDLE:
            begin
                inside_next = pos_in;
                clr_next    = '0;
                pass_next   = '0;
            end
            S_CLEAR:  clr_next = clr_reg + ADDR_W'(1);
            S_LSTART:
            begin
                i_next = $signed(CW'(start_x_reg));
                j_next = $signed(CW'(start_y_reg));
            end
            S_PT:
            begin
                tx_next  = i_reg - rsx;
                ty_next  = j_reg - rsy;
                ty0_next = j_reg - rsy;
                kk_next  = '0;
                ll_next  = '0;
                n_next   = '0;
            end
            S_GATHER:
            begin
                gw_next   = tx_in && ty_in;
                gidx_next = n_reg[WIN_AW-1:0];
                if (tx_in && ty_in)
                begin
                    n_next = n_reg + CNT_W'(1);
                end
                if (ll_reg == span)
                begin
                    ll_next = '0;
                    ty_next = ty0_reg;
                    kk_next = kk_reg + KW'(1);
                    tx_next = tx_reg + sx_c;
                end
                else
                begin
                    ll_next = ll_reg + KW'(1);
                    ty_next = ty_reg + sy_c;
                end
            end
            S_CWAIT:
            begin
                p_next = $signed(img_rdata);
                a_next = '0;
            end
            S_CANDW:
            begin
                cand_next = $signed(win_rdata);
                b_next    = '0;
            end
            S_COUNT:
            begin
                cmp_v_next = 1'b1;
                b_next     = b_reg + CNT_W'(1);
            end
            S_EVAL2:
            begin
                if (!found)
                begin
                    a_next = a_reg + CNT_W'(1);
                end
            end
            S_DEC:
            begin
                if (dec.valid)
                begin
                    if (j_step >= $signed(CW'(IMG_H)))
                    begin
                        j_next = $signed(CW'(start_y_reg));
                        i_next = i_step;
                    end
                    else
                    begin
                        j_next = j_step;
                    end
                end
            end
            S_PEND:
            begin
                bank_next = ~bank_reg;
                pass_next = pass_reg + PASS_W'(1);
                clr_next  = '0;
            end
            default:  gw_next = 1'b0;
        endcase
    end

    // output register: hold until transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_pixel_next = out_pixel_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_pixel_next = out_value;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            bank_reg      <= 1'b0;
            clr_reg       <= '0;
            pass_reg      <= '0;
            kk_reg        <= '0;
            ll_reg        <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            gw_reg        <= 1'b0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            clr_reg       <= clr_next;
            pass_reg      <= pass_next;
            kk_reg        <= kk_next;
            ll_reg        <= ll_next;
            n_reg         <= n_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            gw_reg        <= gw_next;
            cmp_v_reg     <= cmp_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        ty0_reg       <= ty0_next;
        gidx_reg      <= gidx_next;
        inside_reg    <= inside_next;
        cand_reg      <= cand_next;
        p_reg         <= p_next;
        out_pixel_reg <= out_pixel_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RAD_W'(1);
            thresh_reg  <= THR_W'(128);
            passes_reg  <= PASS_W'(1);
            start_x_reg <= '0;
            start_y_reg <= '0;
            step_x_reg  <= STEP_W'(1);
            step_y_reg  <= STEP_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data[RAD_W-1:0];
                REG_THRESH:  thresh_reg  <= cfg_data[THR_W-1:0];
                REG_PASSES:  passes_reg  <= cfg_data[PASS_W-1:0];
                REG_START_X: start_x_reg <= cfg_data[POS_W-1:0];
                REG_START_Y: start_y_reg <= cfg_data[POS_W-1:0];
                REG_STEP_X:  step_x_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_Y:  step_y_reg  <= cfg_data[STEP_W-1:0];
                default:     radius_reg  <= radius_reg;
            endcase
        end
    end

    // image banks: active bank is read, the other is built by a pass
    lmof_ram #(.DEPTH(NPIX), .WIDTH(PIX_W)) u_bank0 (
        .clk   (clk),
        .we    (img_we && !img_wbank),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (rdata0)
    );

    lmof_ram #(.DEPTH(NPIX), .WIDTH(PIX_W)) u_bank1 (
        .clk   (clk),
        .we    (img_we && img_wbank),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (rdata1)
    );

    assign img_rdata = bank_reg ? rdata1 : rdata0;

    // gathered neighbor values
    lmof_ram #(.DEPTH(NWIN), .WIDTH(PIX_W)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (img_rdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    lmof_rank u_rank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rank_ctl),
        .sample ($signed(win_rdata)),
        .cand   (cand_reg),
        .lt_cnt (lt_cnt),
        .le_cnt (le_cnt)
    );

    lmof_outlier u_outlier (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dec_start),
        .p     (p_reg),
        .m     (cand_reg),
        .thr   (thresh_reg),
        .dec   (dec)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pixel_out = out_pixel_reg;

    `LMOF_ASSERT_IMPLY(a_ready_needs_slot, in_ready, (!out_valid_reg || out_ready), "input taken with output slot full")
    `LMOF_ASSERT_IMPLY(a_win_index_range, gw_reg, (32'(gidx_reg) < NWIN), "window write beyond store")
    `LMOF_ASSERT_IMPLY(a_dec_in_state, dec.valid, (state_reg == S_DEC), "outlier result outside decide state")
    `LMOF_ASSERT_NEXT(a_run_busy, (accept && (cmd_c == CMD_RUN)), !in_ready, "ready during run")

endmodule
